[design/cvr_pkg.sv]
// shared types, constants and lookup tables for the circular cordic
// no dependencies
package cvr_pkg;

  // field and datapath widths
  localparam int FW    = 16;  // width of every input and result field
  localparam int GUARD = 14;  // guard fraction bits in vectoring
  localparam int XW    = 32;  // x and y datapath width
  localparam int AW    = 18;  // angle accumulator width
  localparam int GW    = 17;  // gain factor width, signed
  localparam int PW    = XW + GW;  // product width
  localparam int OSH   = 30;  // output scaling shift

  // command codes
  localparam logic CMD_VECTOR = 1'b0;
  localparam logic CMD_ROTATE = 1'b1;

  // angle and rotation constants
  localparam logic signed [FW-1:0] QUARTER_ANG = 16'sd16384;
  localparam logic signed [AW-1:0] QUARTER_ACC = 18'sd16384;
  localparam logic signed [XW-1:0] ROT_ONE     = 32'sd268435456;

  // one beat moving down the row of cells
  typedef struct packed {
    logic                 vld;
    logic                 rot;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] acc;
    logic signed [FW-1:0] ang;
  } cvr_beat_t;

  // arctangent of two to minus index, binary angle
  function automatic logic [FW-1:0] cvr_atan(input logic [4:0] idx);
    logic [FW-1:0] v;
    unique case (idx)
      5'd0:    v = 16'd8192;
      5'd1:    v = 16'd4836;
      5'd2:    v = 16'd2555;
      5'd3:    v = 16'd1297;
      5'd4:    v = 16'd651;
      5'd5:    v = 16'd326;
      5'd6:    v = 16'd163;
      5'd7:    v = 16'd81;
      5'd8:    v = 16'd41;
      5'd9:    v = 16'd20;
      5'd10:   v = 16'd10;
      5'd11:   v = 16'd5;
      5'd12:   v = 16'd3;
      5'd13:   v = 16'd1;
      5'd14:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // inverse cordic gain for stages zero through n, scaled by 65536
  function automatic logic [FW-1:0] cvr_gain(input logic [3:0] n);
    logic [FW-1:0] v;
    unique case (n)
      4'd0:    v = 16'd46341;
      4'd1:    v = 16'd41449;
      4'd2:    v = 16'd40211;
      4'd3:    v = 16'd39901;
      4'd4:    v = 16'd39823;
      4'd5:    v = 16'd39803;
      4'd6:    v = 16'd39799;
      default: v = 16'd39797;
    endcase
    return v;
  endfunction

endpackage

[design/cvr_prerot.sv]
// entry register of the cordic row: fixed-point setup and quadrant pre-rotation
// depends on cvr_pkg
module cvr_prerot import cvr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic                 command_i,
  input  logic signed [FW-1:0] x_in_i,
  input  logic signed [FW-1:0] y_in_i,
  input  logic signed [FW-1:0] angle_in_i,
  output cvr_beat_t            beat_o
);

  cvr_beat_t            beat_d, beat_q;
  logic signed [XW-1:0] xe, ye;

  // scale inputs up by the guard bits
  assign xe = {{(XW-FW-GUARD){x_in_i[FW-1]}}, x_in_i, {GUARD{1'b0}}};
  assign ye = {{(XW-FW-GUARD){y_in_i[FW-1]}}, y_in_i, {GUARD{1'b0}}};

  // starting point per command
  always_comb begin
    beat_d     = '0;
    beat_d.vld = take_i;
    beat_d.rot = command_i;
    beat_d.ang = angle_in_i;
    if (command_i == CMD_VECTOR) begin
      beat_d.x   = xe;
      beat_d.y   = ye;
      beat_d.acc = '0;
      // left half plane: turn into the right half, zero q takes +90
      if (x_in_i[FW-1]) begin
        if (!y_in_i[FW-1] && (y_in_i != '0)) begin
          beat_d.x   = ye;
          beat_d.y   = -xe;
          beat_d.acc = -QUARTER_ACC;
        end else begin
          beat_d.x   = -ye;
          beat_d.y   = xe;
          beat_d.acc = QUARTER_ACC;
        end
      end
    end else begin
      priority if (angle_in_i > QUARTER_ANG) begin
        beat_d.x   = '0;
        beat_d.y   = ROT_ONE;
        beat_d.acc = QUARTER_ACC;
      end else if (angle_in_i < -QUARTER_ANG) begin
        beat_d.x   = '0;
        beat_d.y   = -ROT_ONE;
        beat_d.acc = -QUARTER_ACC;
      end else begin
        beat_d.x   = ROT_ONE;
        beat_d.y   = '0;
        beat_d.acc = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

[design/cvr_cell.sv]
// one cordic micro-rotation cell with a fixed shift, registered output
// depends on cvr_pkg
module cvr_cell import cvr_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [3:0] n_i,
  input  cvr_beat_t beat_i,
  output cvr_beat_t beat_o
);

  localparam logic [4:0]          IdxC = 5'(IDX);
  localparam logic signed [AW-1:0] AtanC = {{(AW-FW){1'b0}}, cvr_atan(IdxC)};

  cvr_beat_t            beat_d, beat_q;
  logic signed [XW-1:0] xs, ys;
  logic        [AW:0]   diff;
  logic                 en, neg;

  assign en   = (IdxC <= {1'b0, n_i});
  assign xs   = beat_i.x >>> IDX;
  assign ys   = beat_i.y >>> IDX;
  assign diff = {{(AW+1-FW){beat_i.ang[FW-1]}}, beat_i.ang} -
                {beat_i.acc[AW-1], beat_i.acc};

  // rotation follows the residual angle, vectoring drives y toward zero
  assign neg = beat_i.rot ? diff[AW] : !beat_i.y[XW-1];

  // micro-rotation, or pass-through past the last stage
  always_comb begin
    beat_d = beat_i;
    if (en) begin
      if (neg) begin
        beat_d.x   = beat_i.x + ys;
        beat_d.y   = beat_i.y - xs;
        beat_d.acc = beat_i.acc - AtanC;
      end else begin
        beat_d.x   = beat_i.x - ys;
        beat_d.y   = beat_i.y + xs;
        beat_d.acc = beat_i.acc + AtanC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

[design/cvr_scale.sv]
// gain correction, rounding, saturation and result registers
// depends on cvr_pkg
module cvr_scale import cvr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0]           n_i,
  input  cvr_beat_t            beat_i,
  output logic                 done_o,
  output logic        [FW-1:0] magnitude_o,
  output logic signed [FW-1:0] phase_out_o,
  output logic signed [FW-1:0] cosine_o,
  output logic signed [FW-1:0] sine_o
);

  localparam int RW = PW - OSH;
  localparam logic signed [PW-1:0] Rnd     = 49'sd536870912;
  localparam logic signed [RW-1:0] MagMax  = 19'sd46341;
  localparam logic signed [RW-1:0] TrigMax = 19'sd16384;
  localparam logic signed [AW-1:0] PhMax   = 18'sd32767;
  localparam logic signed [AW-1:0] PhMin   = -18'sd32768;

  logic signed [GW-1:0] gain;
  logic signed [PW-1:0] px_d, py_d, px_q, py_q, sx, sy;
  logic signed [AW-1:0] acc_q, ph;
  logic                 vld_q, rot_q;
  logic signed [RW-1:0] rx, ry;
  logic        [FW-1:0] mag_d;
  logic signed [FW-1:0] ph_d, cos_d, sin_d;

  // multiply by the inverse gain
  assign gain = $signed({1'b0, cvr_gain(n_i)});
  assign px_d = PW'(beat_i.x) * PW'(gain);
  assign py_d = PW'(beat_i.y) * PW'(gain);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= beat_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    acc_q <= beat_i.acc;
    rot_q <= beat_i.rot;
  end

  // round half up and drop the scaling bits
  assign sx = px_q + Rnd;
  assign sy = py_q + Rnd;
  assign rx = $signed(sx[PW-1:OSH]);
  assign ry = $signed(sy[PW-1:OSH]);
  assign ph = -acc_q;

  // saturate and zero the fields the command does not use
  always_comb begin
    mag_d = '0;
    ph_d  = '0;
    cos_d = '0;
    sin_d = '0;
    if (rot_q == CMD_VECTOR) begin
      priority if (rx[RW-1])   mag_d = '0;
      else if (rx > MagMax)    mag_d = FW'(MagMax);
      else                     mag_d = rx[FW-1:0];
      priority if (ph > PhMax) ph_d = FW'(PhMax);
      else if (ph < PhMin)     ph_d = FW'(PhMin);
      else                     ph_d = ph[FW-1:0];
    end else begin
      priority if (rx > TrigMax) cos_d = FW'(TrigMax);
      else if (rx < -TrigMax)    cos_d = FW'(-TrigMax);
      else                       cos_d = rx[FW-1:0];
      priority if (ry > TrigMax) sin_d = FW'(TrigMax);
      else if (ry < -TrigMax)    sin_d = FW'(-TrigMax);
      else                       sin_d = ry[FW-1:0];
    end
  end

  // result beat registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    magnitude_o <= mag_d;
    phase_out_o <= ph_d;
    cosine_o    <= cos_d;
    sine_o      <= sin_d;
  end

  // only one command's pair of fields is ever nonzero
  a_one_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((magnitude_o == '0) && (phase_out_o == '0)) ||
               ((cosine_o == '0) && (sine_o == '0)))
    else $error("cvr_scale: both result pairs nonzero");

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (magnitude_o <= 16'd46341))
    else $error("cvr_scale: magnitude out of range");

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cosine_o <= 16'sd16384) && (cosine_o >= -16'sd16384) &&
               (sine_o <= 16'sd16384) && (sine_o >= -16'sd16384))
    else $error("cvr_scale: cosine or sine out of range");

endmodule

[design/cordic_vectoring_and_rotation.sv]
// circular cordic top level: config register, entry stage, cell row, output scaling
// depends on cvr_pkg, cvr_prerot, cvr_cell, cvr_scale
//
//   channel   handshake              payload
//   command   start / busy           command_i, x_in_i, y_in_i, angle_in_i
//   result    done_o (strobe)        magnitude_o, phase_out_o, cosine_o, sine_o
//   config    cfg_valid_i/cfg_ready_o cfg_data_i (last_stage)
//
// a new command beat is taken every cycle; busy stays low
// each result passes through the entry register,
// one register per cell, the gain multiply register and the output register
// results are shown for one cycle on done_o and cannot be held off
// reset clears the valid path and sets last_stage to 15
module cordic_vectoring_and_rotation import cvr_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 command_i,
  input  logic signed [FW-1:0] x_in_i,
  input  logic signed [FW-1:0] y_in_i,
  input  logic signed [FW-1:0] angle_in_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [3:0]           cfg_data_i,
  output logic                 done_o,
  output logic        [FW-1:0] magnitude_o,
  output logic signed [FW-1:0] phase_out_o,
  output logic signed [FW-1:0] cosine_o,
  output logic signed [FW-1:0] sine_o
);

  localparam logic [4:0] MaxIdx = 5'(STAGES - 1);

  logic [3:0] last_q, last_d;
  logic [3:0] n;
  cvr_beat_t  beat [STAGES+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // last_stage register
  assign last_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 4'd15;
    end else begin
      last_q <= last_d;
    end
  end

  // final stage index limited by the cells present
  assign n = ({1'b0, last_q} > MaxIdx) ? MaxIdx[3:0] : last_q;

  // entry stage
  cvr_prerot u_prerot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (start && !busy),
    .command_i  (command_i),
    .x_in_i     (x_in_i),
    .y_in_i     (y_in_i),
    .angle_in_i (angle_in_i),
    .beat_o     (beat[0])
  );

  // row of micro-rotation cells
  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    cvr_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .n_i    (n),
      .beat_i (beat[k]),
      .beat_o (beat[k+1])
    );
  end

  // gain correction and result registers
  cvr_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n),
    .beat_i      (beat[STAGES]),
    .done_o      (done_o),
    .magnitude_o (magnitude_o),
    .phase_out_o (phase_out_o),
    .cosine_o    (cosine_o),
    .sine_o      (sine_o)
  );

endmodule
